// ===== src/kmrc_pkg.sv =====
package kmrc_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_K_DEF      = 8;
   localparam int COUNT_BITS_DEF = 31;

   // Fixed widths of the ports
   localparam int KLEN_W  = 4;
   localparam int VALUE_W = 31;
   localparam int INDEX_W = 16;
   localparam int CSR_W   = 2;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Item function codes
   localparam logic [2:0] FUNC_COUNT_FWD  = 3'd0;
   localparam logic [2:0] FUNC_COUNT_BOTH = 3'd1;
   localparam logic [2:0] FUNC_LOOKUP     = 3'd2;
   localparam logic [2:0] FUNC_WRITE      = 3'd3;
   localparam logic [2:0] FUNC_READ       = 3'd4;
   localparam logic [2:0] FUNC_CLEAR      = 3'd5;

   // Table operations handed from front to back
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_BUMP1  = 3'd1;
   localparam logic [2:0] OP_BUMP2  = 3'd2;
   localparam logic [2:0] OP_LOOKUP = 3'd3;
   localparam logic [2:0] OP_WRITE  = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;
   localparam logic [2:0] OP_CLEAR  = 3'd6;

   // Configuration register indexes
   localparam logic [CSR_W-1:0] CSR_KMER_LEN   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_FILL_VALUE = 2'd1;

   // Status from back to front
   typedef struct packed {
      logic init_busy;
   } kmrc_status_type;

   // Width of one queued command: op, two addresses, value, sat, ready,
   // two reported indices, bad flag
   function automatic int cmd_bits(input int max_k, input int count_bits);
      return 3 + 4 * max_k + count_bits + 1 + 1 + 2 * INDEX_W + 1;
   endfunction

endpackage

// ===== src/kmrc_queue.sv =====
module kmrc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    fill_ff, fill_in;

   assign full      = (fill_ff == CW'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/kmrc_front.sv =====
module kmrc_front #(
   parameter int MAX_K      = kmrc_pkg::MAX_K_DEF,
   parameter int COUNT_BITS = kmrc_pkg::COUNT_BITS_DEF,
   parameter int QW         = kmrc_pkg::cmd_bits(MAX_K, COUNT_BITS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_func,
   input  logic                         req_first,
   input  logic [7:0]                   req_nucleotide,
   input  logic [kmrc_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [kmrc_pkg::VALUE_W-1:0] req_entry_value,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [kmrc_pkg::CSR_W-1:0]   csr_index,
   input  logic [kmrc_pkg::VALUE_W-1:0] csr_data,
   input  kmrc_pkg::kmrc_status_type    status,
   input  logic                         q_full,
   output logic                         q_push,
   output logic [QW-1:0]                q_data
);
   import kmrc_pkg::*;

   localparam int W  = 2 * MAX_K;
   localparam int TW = 2 * MAX_K;
   localparam int VW = (COUNT_BITS > VALUE_W) ? COUNT_BITS : VALUE_W;
   localparam logic [VW-1:0] COUNT_MAX_EXT = VW'({COUNT_BITS{1'b1}});

   typedef struct packed {
      logic [2:0]            op;
      logic [TW-1:0]         addr_a;
      logic [TW-1:0]         addr_b;
      logic [COUNT_BITS-1:0] value;
      logic                  sat;
      logic                  ready;
      logic [INDEX_W-1:0]    kidx;
      logic [INDEX_W-1:0]    ridx;
      logic                  bad;
   } cmd_type;

   logic [W-1:0]        fwd_ff, fwd_in;
   logic [W-1:0]        rc_ff, rc_in;
   logic [KLEN_W-1:0]   seen_ff, seen_in;
   logic [KLEN_W-1:0]   kmer_len_ff;
   logic [VALUE_W-1:0]  fill_ff;

   logic [KLEN_W-1:0]   k_eff;
   logic [KLEN_W:0]     two_k;
   logic [KLEN_W:0]     top_shift;
   logic [W-1:0]        kmask;
   logic [W-1:0]        fwd_base, rc_base;
   logic [KLEN_W-1:0]   seen_base;
   logic [1:0]          base;
   logic                accept;
   logic                is_base_func;
   logic                kmer_full;
   logic [VW-1:0]       value_ext;
   cmd_type             cmd;

   assign req_ready = !q_full && !status.init_busy;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;
   assign q_data    = cmd;

   // Effective k, clamped to 1..MAX_K
   always_comb begin
      if (kmer_len_ff == '0) begin
         k_eff = KLEN_W'(1);
      end else if (kmer_len_ff > KLEN_W'(MAX_K)) begin
         k_eff = KLEN_W'(MAX_K);
      end else begin
         k_eff = kmer_len_ff;
      end
      two_k     = {k_eff, 1'b0};
      top_shift = {k_eff - 1'b1, 1'b0};
      for (int i = 0; i < W; i++) begin
         kmask[i] = ((KLEN_W + 1)'(i) < two_k);
      end
   end

   // Window update and item classification
   always_comb begin
      is_base_func = (req_func inside {FUNC_COUNT_FWD, FUNC_COUNT_BOTH, FUNC_LOOKUP});
      base         = req_nucleotide[1:0];
      fwd_in       = fwd_ff;
      rc_in        = rc_ff;
      seen_in      = seen_ff;
      fwd_base     = req_first ? '0 : fwd_ff;
      rc_base      = req_first ? '0 : rc_ff;
      seen_base    = req_first ? '0 : seen_ff;
      kmer_full    = 1'b0;
      value_ext    = '0;

      cmd        = '0;
      cmd.op     = OP_NONE;
      cmd.addr_a = TW'(req_entry_index);
      cmd.addr_b = TW'(req_entry_index);

      if (is_base_func) begin
         if (req_nucleotide > 8'd3) begin
            // bad code: window restarts, nothing touches the table
            fwd_in  = '0;
            rc_in   = '0;
            seen_in = '0;
            cmd.bad = 1'b1;
         end else begin
            fwd_in  = {fwd_base[W-3:0], base} & kmask;
            rc_in   = ((rc_base >> 2) | (W'(~base) << top_shift)) & kmask;
            seen_in = (seen_base < k_eff) ? seen_base + 1'b1 : seen_base;
            kmer_full = (seen_in >= k_eff);
            if (kmer_full) begin
               cmd.addr_a = fwd_in;
               cmd.addr_b = rc_in;
               case (req_func)
                  FUNC_COUNT_FWD:  cmd.op = OP_BUMP1;
                  FUNC_COUNT_BOTH: cmd.op = OP_BUMP2;
                  default:         cmd.op = OP_LOOKUP;
               endcase
            end
         end
      end else begin
         case (req_func)
            FUNC_WRITE: begin
               value_ext = VW'(req_entry_value);
               cmd.op    = OP_WRITE;
            end
            FUNC_READ: begin
               cmd.op = OP_READ;
            end
            FUNC_CLEAR: begin
               value_ext = VW'(fill_ff);
               cmd.op    = OP_CLEAR;
            end
            default: begin
               cmd.op = OP_NONE;
            end
         endcase
      end

      // Clip stored values to the count range
      if (value_ext > COUNT_MAX_EXT) begin
         cmd.sat   = 1'b1;
         cmd.value = {COUNT_BITS{1'b1}};
      end else begin
         cmd.value = COUNT_BITS'(value_ext);
      end

      cmd.ready = (seen_in >= k_eff);
      cmd.kidx  = INDEX_W'(fwd_in);
      cmd.ridx  = INDEX_W'(rc_in);
   end

   // Window and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff      <= '0;
         rc_ff       <= '0;
         seen_ff     <= '0;
         kmer_len_ff <= KLEN_W'(8);
         fill_ff     <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KMER_LEN: begin
                  kmer_len_ff <= csr_data[KLEN_W-1:0];
                  fwd_ff      <= '0;
                  rc_ff       <= '0;
                  seen_ff     <= '0;
               end
               CSR_FILL_VALUE: begin
                  fill_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end else if (accept) begin
            fwd_ff  <= fwd_in;
            rc_ff   <= rc_in;
            seen_ff <= seen_in;
         end
      end
   end

endmodule

// ===== src/kmrc_back.sv =====
module kmrc_back #(
   parameter int MAX_K      = kmrc_pkg::MAX_K_DEF,
   parameter int COUNT_BITS = kmrc_pkg::COUNT_BITS_DEF,
   parameter int QW         = kmrc_pkg::cmd_bits(MAX_K, COUNT_BITS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_not_empty,
   input  logic [QW-1:0]                q_data,
   output logic                         q_pop,
   output kmrc_pkg::kmrc_status_type    status,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_kmer_ready,
   output logic [kmrc_pkg::INDEX_W-1:0] rsp_kmer_index,
   output logic [kmrc_pkg::INDEX_W-1:0] rsp_revcomp_index,
   output logic [kmrc_pkg::VALUE_W-1:0] rsp_count,
   output logic                         rsp_bad_base,
   output logic                         rsp_saturated
);
   import kmrc_pkg::*;

   localparam int TW    = 2 * MAX_K;
   localparam int DEPTH = 1 << TW;

   typedef struct packed {
      logic [2:0]            op;
      logic [TW-1:0]         addr_a;
      logic [TW-1:0]         addr_b;
      logic [COUNT_BITS-1:0] value;
      logic                  sat;
      logic                  ready;
      logic [INDEX_W-1:0]    kidx;
      logic [INDEX_W-1:0]    ridx;
      logic                  bad;
   } cmd_type;

   // Sequencer states
   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_RDA   = 3'd3;
   localparam logic [2:0] S_ISSB  = 3'd4;
   localparam logic [2:0] S_RDB   = 3'd5;
   localparam logic [2:0] S_CLEAR = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [COUNT_BITS-1:0] table_mem [DEPTH];
   logic [COUNT_BITS-1:0] rd_data_ff;

   logic [2:0]            state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [TW-1:0]         sweep_ff, sweep_in;
   logic [COUNT_BITS-1:0] res_count_ff, res_count_in;
   logic                  res_sat_ff, res_sat_in;

   logic                  rsp_valid_ff;
   logic                  rsp_kmer_ready_ff;
   logic [INDEX_W-1:0]    rsp_kmer_index_ff;
   logic [INDEX_W-1:0]    rsp_revcomp_index_ff;
   logic [VALUE_W-1:0]    rsp_count_ff;
   logic                  rsp_bad_base_ff;
   logic                  rsp_saturated_ff;

   logic                  mem_we;
   logic [TW-1:0]         mem_wa;
   logic [TW-1:0]         mem_ra;
   logic [COUNT_BITS-1:0] mem_wd;
   logic [COUNT_BITS-1:0] bumped;
   logic                  bump_sat;
   logic                  out_load;

   assign status.init_busy = (state_ff == S_INIT);
   assign out_load         = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // Saturating increment of the entry just read
   always_comb begin
      bump_sat = (rd_data_ff == {COUNT_BITS{1'b1}});
      bumped   = bump_sat ? rd_data_ff : rd_data_ff + 1'b1;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      sweep_in     = sweep_ff;
      res_count_in = res_count_ff;
      res_sat_in   = res_sat_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = cmd_ff.addr_a;
      mem_wd       = cmd_ff.value;
      mem_ra       = cmd_ff.addr_a;

      case (state_ff)
         S_INIT: begin
            // table starts out zero after reset
            mem_we   = 1'b1;
            mem_wa   = sweep_ff;
            mem_wd   = '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == {TW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_count_in = '0;
            res_sat_in   = cmd_ff.sat;
            case (cmd_ff.op)
               OP_WRITE: begin
                  mem_we       = 1'b1;
                  res_count_in = cmd_ff.value;
                  state_in     = S_OUT;
               end
               OP_READ, OP_LOOKUP, OP_BUMP1, OP_BUMP2: begin
                  state_in = S_RDA;
               end
               OP_CLEAR: begin
                  sweep_in = '0;
                  state_in = S_CLEAR;
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_RDA: begin
            if (cmd_ff.op == OP_BUMP1 || cmd_ff.op == OP_BUMP2) begin
               mem_we       = 1'b1;
               mem_wd       = bumped;
               res_count_in = bumped;
               res_sat_in   = res_sat_ff | bump_sat;
               state_in     = (cmd_ff.op == OP_BUMP2) ? S_ISSB : S_OUT;
            end else begin
               res_count_in = rd_data_ff;
               state_in     = S_OUT;
            end
         end
         S_ISSB: begin
            // read of the second entry after the first write has landed
            mem_ra   = cmd_ff.addr_b;
            state_in = S_RDB;
         end
         S_RDB: begin
            mem_we     = 1'b1;
            mem_wa     = cmd_ff.addr_b;
            mem_wd     = bumped;
            res_sat_in = res_sat_ff | bump_sat;
            if (cmd_ff.addr_b == cmd_ff.addr_a) begin
               res_count_in = bumped;
            end
            state_in = S_OUT;
         end
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_wa   = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == {TW{1'b1}}) begin
               res_count_in = cmd_ff.value;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      res_count_ff <= res_count_in;
      res_sat_ff   <= res_sat_in;
   end

   // Count table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= table_mem[mem_ra];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kmer_ready_ff    <= cmd_ff.ready;
         rsp_kmer_index_ff    <= cmd_ff.kidx;
         rsp_revcomp_index_ff <= cmd_ff.ridx;
         rsp_count_ff         <= VALUE_W'(res_count_ff);
         rsp_bad_base_ff      <= cmd_ff.bad;
         rsp_saturated_ff     <= res_sat_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kmer_ready    = rsp_kmer_ready_ff;
   assign rsp_kmer_index    = rsp_kmer_index_ff;
   assign rsp_revcomp_index = rsp_revcomp_index_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_bad_base      = rsp_bad_base_ff;
   assign rsp_saturated     = rsp_saturated_ff;

endmodule

// ===== src/kmer_rolling_count_table.sv =====
// Flow: no-op, bad-base, partial-window and write items go from execute straight to output;
// lookup and read add a table read, forward count a read and write-back, forward plus
// reverse-complement a second read and write-back. The back sequencer finishes each item
// before it pops the next from the queue, and a clear item sweeps all 4^MAX_K table entries
// (65536 by default). Reset: synchronous; windows clear and registers take their reset values,
// then a zeroing pass runs over the table with req_ready low. Csr writes are taken.
module kmer_rolling_count_table #(
   parameter int MAX_K      = kmrc_pkg::MAX_K_DEF,
   parameter int COUNT_BITS = kmrc_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_func,
   input  logic                         req_first,
   input  logic [7:0]                   req_nucleotide,
   input  logic [kmrc_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [kmrc_pkg::VALUE_W-1:0] req_entry_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_kmer_ready,
   output logic [kmrc_pkg::INDEX_W-1:0] rsp_kmer_index,
   output logic [kmrc_pkg::INDEX_W-1:0] rsp_revcomp_index,
   output logic [kmrc_pkg::VALUE_W-1:0] rsp_count,
   output logic                         rsp_bad_base,
   output logic                         rsp_saturated,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [kmrc_pkg::CSR_W-1:0]   csr_index,
   input  logic [kmrc_pkg::VALUE_W-1:0] csr_data
);
   import kmrc_pkg::*;

   localparam int QW = cmd_bits(MAX_K, COUNT_BITS);

   kmrc_status_type status;
   logic            q_full;
   logic            q_push;
   logic            q_pop;
   logic            q_not_empty;
   logic [QW-1:0]   q_push_data;
   logic [QW-1:0]   q_head_data;

   // Front: windows, configuration, classification
   kmrc_front #(
      .MAX_K      (MAX_K),
      .COUNT_BITS (COUNT_BITS),
      .QW         (QW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_first       (req_first),
      .req_nucleotide  (req_nucleotide),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .status          (status),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_push_data)
   );

   // Command queue
   kmrc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (q_head_data)
   );

   // Back: table sequencer and result register
   kmrc_back #(
      .MAX_K      (MAX_K),
      .COUNT_BITS (COUNT_BITS),
      .QW         (QW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_data            (q_head_data),
      .q_pop             (q_pop),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kmer_ready    (rsp_kmer_ready),
      .rsp_kmer_index    (rsp_kmer_index),
      .rsp_revcomp_index (rsp_revcomp_index),
      .rsp_count         (rsp_count),
      .rsp_bad_base      (rsp_bad_base),
      .rsp_saturated     (rsp_saturated)
   );

endmodule

// ===== tb/kmer_rolling_count_table_tb.sv =====
`timescale 1ns / 100ps

module kmer_rolling_count_table_tb;
   import kmrc_pkg::*;

   // Function codes with no table operation
   localparam logic [2:0] FUNC_UNUSED6 = 3'd6;
   localparam logic [2:0] FUNC_UNUSED7 = 3'd7;

   localparam logic [VALUE_W-1:0] COUNT_MAX = {VALUE_W{1'b1}};
   localparam int TABLE_ENTRIES = 1 << (2 * MAX_K_DEF);
   localparam int CYCLE_LIMIT = 4000000;
   localparam int MAX_SEND_GAP = 30;

   typedef struct packed {
      logic               kmer_ready;
      logic [INDEX_W-1:0] kmer_index;
      logic [INDEX_W-1:0] revcomp_index;
      logic [VALUE_W-1:0] count;
      logic               bad_base;
      logic               saturated;
   } kmer_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_func = FUNC_COUNT_FWD;
   logic               req_first = 1'b0;
   logic [7:0]         req_nucleotide = 8'd0;
   logic [INDEX_W-1:0] req_entry_index = '0;
   logic [VALUE_W-1:0] req_entry_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_kmer_ready;
   logic [INDEX_W-1:0] rsp_kmer_index;
   logic [INDEX_W-1:0] rsp_revcomp_index;
   logic [VALUE_W-1:0] rsp_count;
   logic               rsp_bad_base;
   logic               rsp_saturated;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_W-1:0]   csr_index = CSR_KMER_LEN;
   logic [VALUE_W-1:0] csr_data = '0;

   // Predicted block state
   logic [KLEN_W-1:0]  model_kmer_len = 4'd8;
   logic [VALUE_W-1:0] model_fill = '0;
   logic [31:0]        fwd_kmer = '0;
   logic [31:0]        rc_kmer = '0;
   int unsigned        bases_in_window = 0;
   bit [VALUE_W-1:0]   count_store [0:TABLE_ENTRIES-1];

   kmer_result_type kmer_results_due [$];
   int wrong_results = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int clears_left = 4;

   kmer_rolling_count_table uut (.*);

   always #4 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Result checker: oldest expectation first
   always @(posedge clock) begin
      kmer_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (kmer_results_due.size() == 0) begin
            if (wrong_results < 10)
               $display("unexpected result item: count=%h kidx=%h", rsp_count, rsp_kmer_index);
            wrong_results++;
         end else begin
            want = kmer_results_due.pop_front();
            if (rsp_kmer_ready !== want.kmer_ready || rsp_kmer_index !== want.kmer_index ||
                rsp_revcomp_index !== want.revcomp_index || rsp_count !== want.count ||
                rsp_bad_base !== want.bad_base || rsp_saturated !== want.saturated) begin
               if (wrong_results < 10)
                  $display({"mismatch exp rdy=%0d kidx=%h rc=%h cnt=%h bad=%0d sat=%0d",
                            " | got rdy=%0d kidx=%h rc=%h cnt=%h bad=%0d sat=%0d"},
                           want.kmer_ready, want.kmer_index, want.revcomp_index, want.count,
                           want.bad_base, want.saturated, rsp_kmer_ready, rsp_kmer_index,
                           rsp_revcomp_index, rsp_count, rsp_bad_base, rsp_saturated);
               wrong_results++;
            end
         end
      end
   end

   function automatic void empty_window();
      fwd_kmer = '0;
      rc_kmer = '0;
      bases_in_window = 0;
   endfunction

   // Saturating increment of one entry; returns 1 when it was already full
   function automatic bit bump_entry(input logic [INDEX_W-1:0] slot);
      if (count_store[slot] >= COUNT_MAX) begin
         count_store[slot] = COUNT_MAX;
         return 1'b1;
      end
      count_store[slot] = count_store[slot] + 1'b1;
      return 1'b0;
   endfunction

   // Advance windows and table for one item, return the result it yields
   function automatic kmer_result_type step_count_table(input logic [2:0] func,
                                                       input logic first,
                                                       input logic [7:0] nuc,
                                                       input logic [INDEX_W-1:0] slot,
                                                       input logic [VALUE_W-1:0] value);
      kmer_result_type res;
      int unsigned k;
      logic [31:0] kmask;
      logic [31:0] base;
      k = 32'(model_kmer_len);
      if (k < 1) k = 1;
      if (k > MAX_K_DEF) k = MAX_K_DEF;
      kmask = (32'd1 << (2 * k)) - 1;
      base = {24'd0, nuc};
      res = '0;
      if (func <= FUNC_LOOKUP) begin
         if (first) empty_window();
         if (base > 3) begin
            res.bad_base = 1'b1;
            empty_window();
         end else begin
            fwd_kmer = ((fwd_kmer << 2) | base) & kmask;
            rc_kmer = ((rc_kmer >> 2) | ((32'd3 - base) << (2 * (k - 1)))) & kmask;
            if (bases_in_window < k) bases_in_window++;
            if (bases_in_window >= k) begin
               if (func != FUNC_LOOKUP)
                  res.saturated = bump_entry(fwd_kmer[INDEX_W-1:0]);
               if (func == FUNC_COUNT_BOTH)
                  res.saturated = bump_entry(rc_kmer[INDEX_W-1:0]) | res.saturated;
               res.count = count_store[fwd_kmer[INDEX_W-1:0]];
            end
         end
      end else if (func == FUNC_WRITE) begin
         count_store[slot] = value;
         res.count = value;
      end else if (func == FUNC_READ) begin
         res.count = count_store[slot];
      end else if (func == FUNC_CLEAR) begin
         foreach (count_store[i]) count_store[i] = model_fill;
         res.count = model_fill;
      end
      res.kmer_ready = (bases_in_window >= k);
      res.kmer_index = fwd_kmer[INDEX_W-1:0];
      res.revcomp_index = rc_kmer[INDEX_W-1:0];
      return res;
   endfunction

   // Offer one item after an optional idle gap; valid is left high on return
   task automatic send_kmer_item(input logic [2:0] func, input logic first, input logic [7:0] nuc,
                                 input logic [INDEX_W-1:0] slot, input logic [VALUE_W-1:0] value);
      int gap;
      kmer_result_type due;
      gap = 0;
      while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_first <= first;
      req_nucleotide <= nuc;
      req_entry_index <= slot;
      req_entry_value <= value;
      do @(posedge clock); while (!req_ready);
      due = step_count_table(func, first, nuc, slot, value);
      kmer_results_due = {kmer_results_due, due};
   endtask

   // Base item with random don't-care fields
   task automatic send_base(input logic [2:0] func, input logic first, input logic [7:0] nuc);
      send_kmer_item(func, first, nuc, 16'($urandom_range(65535)), 31'($urandom()));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (kmer_results_due.size() != 0) @(posedge clock);
   endtask

   // Write both registers; only called with no item in flight
   task automatic configure_table(input logic [KLEN_W-1:0] klen, input logic [VALUE_W-1:0] fill);
      csr_valid <= 1'b1;
      csr_index <= CSR_KMER_LEN;
      csr_data <= {{(VALUE_W - KLEN_W){1'b0}}, klen};
      do @(posedge clock); while (!csr_ready);
      model_kmer_len = klen;
      empty_window();
      csr_index <= CSR_FILL_VALUE;
      csr_data <= fill;
      do @(posedge clock); while (!csr_ready);
      model_fill = fill;
      csr_valid <= 1'b0;
   endtask

   // Reset k of 8: partial window, then a full k-mer and a lookup
   task automatic test_full_window_default_k();
      logic [7:0] bases [8];
      bases = '{8'd3, 8'd0, 8'd1, 8'd2, 8'd3, 8'd3, 8'd0, 8'd0};
      foreach (bases[i]) send_base(FUNC_COUNT_FWD, i == 0, bases[i]);
      send_base(FUNC_LOOKUP, 1'b0, 8'd2);
   endtask

   // Codes above 3 empty the window; first restarts it
   task automatic test_bad_base();
      send_base(FUNC_COUNT_FWD, 1'b0, 8'hFF);
      send_base(FUNC_COUNT_BOTH, 1'b0, 8'd1);
      send_base(FUNC_LOOKUP, 1'b1, 8'd4);
   endtask

   // k of 2: AT is its own reverse complement, counted twice
   task automatic test_palindrome_both_strands();
      drain_results();
      configure_table(4'd2, COUNT_MAX);
      send_base(FUNC_COUNT_BOTH, 1'b1, 8'd0);
      send_base(FUNC_COUNT_BOTH, 1'b0, 8'd3);
   endtask

   // Entry one below full: first bump fills it, second one saturates
   task automatic test_saturation();
      send_kmer_item(FUNC_WRITE, 1'b0, 8'd0, 16'd3, COUNT_MAX - 1'b1);
      send_base(FUNC_COUNT_BOTH, 1'b1, 8'd0);
      send_base(FUNC_COUNT_BOTH, 1'b0, 8'd3);
      send_kmer_item(FUNC_WRITE, 1'b1, 8'hFF, 16'hFFFF, COUNT_MAX);
      send_kmer_item(FUNC_READ, 1'b1, 8'hFF, 16'hFFFF, '0);
   endtask

   task automatic test_unused_funcs();
      send_kmer_item(FUNC_UNUSED6, 1'b1, 8'hFF, 16'hFFFF, COUNT_MAX);
      send_kmer_item(FUNC_UNUSED7, 1'b0, 8'h00, 16'h0000, '0);
   endtask

   // Clear to full scale, read back, then clear to zero
   task automatic test_table_clear();
      send_kmer_item(FUNC_CLEAR, 1'b0, 8'd0, 16'd0, '0);
      send_kmer_item(FUNC_READ, 1'b0, 8'd0, 16'h8000, '0);
      drain_results();
      configure_table(4'd2, '0);
      send_kmer_item(FUNC_CLEAR, 1'b1, 8'hFF, 16'hFFFF, COUNT_MAX);
   endtask

   // Mostly base runs with random content, plus table access and noise
   task automatic run_random_phase(input int send_pct, input int stall_pct,
                                   input logic [KLEN_W-1:0] klen,
                                   input logic [VALUE_W-1:0] fill, input int n_items);
      int run_left;
      int pick;
      logic [2:0] func;
      logic first;
      logic [7:0] nuc;
      logic [INDEX_W-1:0] slot;
      logic [VALUE_W-1:0] value;
      drain_results();
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      configure_table(klen, fill);
      run_left = 0;
      repeat (n_items) begin
         first = 1'($urandom_range(1));
         nuc = 8'($urandom_range(255));
         slot = 16'($urandom_range(65535));
         value = 31'($urandom());
         pick = $urandom_range(99);
         if (pick < 70) begin
            // well-formed base run
            if (run_left == 0) begin
               run_left = $urandom_range(24, 1);
               first = 1'b1;
            end else begin
               first = ($urandom_range(49) == 0);
            end
            run_left--;
            pick = $urandom_range(99);
            func = (pick < 50) ? FUNC_COUNT_FWD : (pick < 85) ? FUNC_COUNT_BOTH : FUNC_LOOKUP;
            nuc = 8'($urandom_range(3));
         end else if (pick < 74) begin
            func = 3'($urandom_range(2));
            nuc = 8'($urandom_range(255, 4));
            run_left = 0;
         end else if (pick < 94) begin
            func = (pick < 82) ? FUNC_WRITE : FUNC_READ;
            // small indexes collide with short k-mers
            if ($urandom_range(1)) slot = 16'($urandom_range(15));
            case ($urandom_range(3))
               0: begin
                  value = COUNT_MAX;
               end
               1: begin
                  value = COUNT_MAX - 31'($urandom_range(2));
               end
               default: begin
               end
            endcase
         end else if (pick < 98 || clears_left == 0) begin
            func = $urandom_range(1) ? FUNC_UNUSED6 : FUNC_UNUSED7;
         end else begin
            func = FUNC_CLEAR;
            clears_left--;
         end
         send_kmer_item(func, first, nuc, slot, value);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_full_window_default_k();
      test_bad_base();
      test_palindrome_both_strands();
      test_saturation();
      test_unused_funcs();
      test_table_clear();
      run_random_phase(0, 0, 4'd15, COUNT_MAX, 310);
      run_random_phase(88, 0, 4'd0, 31'($urandom()), 310);
      run_random_phase(0, 88, 4'd4, '0, 310);
      run_random_phase(38, 38, 4'd1, 31'd1, 310);
      run_random_phase(0, 0, 4'd8, 31'($urandom()), 310);
      drain_results();
      repeat (20) @(posedge clock);
      if (wrong_results == 0 && kmer_results_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
